FILE: src/rtca_pkg.sv
// rtca_pkg: shared widths, codes and record types of the rule table cell array.
// Used by rtca_cell, rtca_seq and rule_table_cell_array_unit; depends on nothing.

package rtca_pkg;

  localparam int MAX_CELLS   = 32;
  localparam int MAX_RULES   = 64;
  localparam int SIG_W       = 7;
  localparam int CELL_IDX_W  = $clog2(MAX_CELLS);
  localparam int NUM_CELLS_W = 6;
  localparam int RULE_IDX_W  = $clog2(MAX_RULES);
  localparam int RULE_CNT_W  = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int MIN_CELLS   = 3;

  // edge inputs of the array and reset value of the cell outputs
  localparam logic [SIG_W-1:0] LEFT_EDGE_FIRST = SIG_W'(31);
  localparam logic [SIG_W-1:0] LEFT_EDGE_LATER = SIG_W'(32);
  localparam logic [SIG_W-1:0] RIGHT_EDGE      = SIG_W'(30);
  localparam logic [SIG_W-1:0] OUT_RESET       = SIG_W'(1);

  // commands
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // lamp codes
  localparam logic [1:0] LED_KEEP = 2'd0;
  localparam logic [1:0] LED_ON   = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CELLS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_STATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic [SIG_W-1:0] st;
    logic [SIG_W-1:0] lin;
    logic [SIG_W-1:0] rin;
    logic [SIG_W-1:0] nxt;
    logic [SIG_W-1:0] lout;
    logic [SIG_W-1:0] rout;
    logic [1:0]       led;
  } rule_t;

  typedef struct packed {
    logic [SIG_W-1:0] st;
    logic [SIG_W-1:0] lout;
    logic [SIG_W-1:0] rout;
    logic             lamp;
    logic             changed;
  } report_t;

  // sequencer to cell row
  typedef struct packed {
    logic capture;     // latch neighbor inputs, open a tick
    logic restart;     // return cells to reset contents
    logic rule_valid;  // broadcast rule is live this cycle
    logic commit;      // load report registers
    logic shift;       // move reports one cell to the left
  } cell_ctl_t;

endpackage

FILE: src/rtca_cell.sv
// rtca_cell: one automaton cell; matches broadcast rules and shifts its report left.
// Depends on rtca_pkg.

module rtca_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  rtca_pkg::cell_ctl_t          ctl,
  input  rtca_pkg::rule_t              rule,
  input  logic [rtca_pkg::SIG_W-1:0]   init_state,
  input  logic [rtca_pkg::SIG_W-1:0]   lin,
  input  logic [rtca_pkg::SIG_W-1:0]   rin,
  input  logic                         active,
  input  rtca_pkg::report_t            report_in,
  output rtca_pkg::report_t            report_out,
  output logic [rtca_pkg::SIG_W-1:0]   lout,
  output logic [rtca_pkg::SIG_W-1:0]   rout
);

  logic [rtca_pkg::SIG_W-1:0] st;
  logic                       lamp;
  logic [rtca_pkg::SIG_W-1:0] lin_q;
  logic [rtca_pkg::SIG_W-1:0] rin_q;
  logic                       active_q;
  logic                       found;
  logic                       changed;
  rtca_pkg::report_t          report;
  logic                       hit;
  logic                       diff;
  logic                       lamp_new;

  assign lamp_new = (rule.led == rtca_pkg::LED_ON);

  always_comb begin
    hit = ctl.rule_valid && active_q && !found && (rule.st == st) &&
          ((rule.lin == lin_q) || (rule.lin == '0)) &&
          ((rule.rin == rin_q) || (rule.rin == '0));
    diff = (rule.nxt != st) ||
           ((rule.lout != '0) && (rule.lout != lout)) ||
           ((rule.rout != '0) && (rule.rout != rout)) ||
           ((rule.led != rtca_pkg::LED_KEEP) && (lamp_new != lamp));
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      // reset takes the reset value of the initial state register
      st    <= rst ? '0 : init_state;
      lout  <= rtca_pkg::OUT_RESET;
      rout  <= rtca_pkg::OUT_RESET;
      lamp  <= 1'b0;
      found <= 1'b0;
    end else if (ctl.capture) begin
      found <= 1'b0;
    end else if (hit) begin
      found <= 1'b1;
      st    <= rule.nxt;
      if (rule.lout != '0) lout <= rule.lout;
      if (rule.rout != '0) rout <= rule.rout;
      if (rule.led != rtca_pkg::LED_KEEP) lamp <= lamp_new;
    end
  end

  // tick-local payload
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      lin_q    <= lin;
      rin_q    <= rin;
      active_q <= active;
      changed  <= 1'b0;
    end else if (hit) begin
      changed <= diff;
    end
    if (ctl.commit) begin
      report <= '{st: st, lout: lout, rout: rout, lamp: lamp, changed: changed};
    end else if (ctl.shift) begin
      report <= report_in;
    end
  end

  assign report_out = report;

endmodule

FILE: src/rtca_seq.sv
// rtca_seq: command sequencer, rule memory and rule broadcast for the cell row.
// Depends on rtca_pkg.

module rtca_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [1:0]                        cmd,
  input  logic [rtca_pkg::RULE_IDX_W-1:0]   rule_index,
  input  rtca_pkg::rule_t                   wr_rule,
  input  logic [rtca_pkg::CELL_IDX_W-1:0]   last_cell,
  input  logic [rtca_pkg::RULE_CNT_W-1:0]   n_rules,
  output rtca_pkg::cell_ctl_t               ctl,
  output rtca_pkg::rule_t                   rule,
  output logic [rtca_pkg::SIG_W-1:0]        left_edge,
  output logic                              busy,
  output logic                              strobe,
  output logic [rtca_pkg::CELL_IDX_W-1:0]   out_idx,
  output logic                              out_last
);

  rtca_pkg::seq_state_t state, state_next;
  rtca_pkg::rule_t      mem [rtca_pkg::MAX_RULES];
  logic [rtca_pkg::RULE_CNT_W-1:0] rd_cnt;
  logic                 rule_valid;
  logic                 first_pending;
  logic                 accept;
  logic                 more;

  assign accept = start && (state == rtca_pkg::ST_IDLE);
  assign more   = (rd_cnt < n_rules);

  always_ff @(posedge clk) begin
    if (accept && (cmd == rtca_pkg::CMD_WRITE)) mem[rule_index] <= wr_rule;
    rule <= mem[rd_cnt[rtca_pkg::RULE_IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rtca_pkg::ST_IDLE;
      rd_cnt        <= '0;
      out_idx       <= '0;
      rule_valid    <= 1'b0;
      first_pending <= 1'b1;
    end else begin
      state      <= state_next;
      rule_valid <= (state == rtca_pkg::ST_SEARCH) && more;
      if (ctl.capture) begin
        rd_cnt        <= '0;
        first_pending <= 1'b0;
      end else if ((state == rtca_pkg::ST_SEARCH) && more) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      if (ctl.restart) first_pending <= 1'b1;
      if (ctl.commit) out_idx <= '0;
      else if (ctl.shift) out_idx <= out_idx + 1'b1;
    end
  end

  always_comb begin
    state_next     = state;
    ctl            = '0;
    ctl.rule_valid = rule_valid;
    strobe         = 1'b0;
    case (state)
      rtca_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd)
            rtca_pkg::CMD_TICK: begin
              ctl.capture = 1'b1;
              state_next  = rtca_pkg::ST_SEARCH;
            end
            rtca_pkg::CMD_RESTART: ctl.restart = 1'b1;
            default: ;
          endcase
        end
      end
      rtca_pkg::ST_SEARCH: begin
        if (!more) state_next = rtca_pkg::ST_COMMIT;
      end
      rtca_pkg::ST_COMMIT: begin
        ctl.commit = 1'b1;
        state_next = rtca_pkg::ST_EMIT;
      end
      rtca_pkg::ST_EMIT: begin
        strobe    = 1'b1;
        ctl.shift = 1'b1;
        if (out_idx == last_cell) state_next = rtca_pkg::ST_IDLE;
      end
      default: state_next = rtca_pkg::ST_IDLE;
    endcase
  end

  assign busy      = (state != rtca_pkg::ST_IDLE);
  assign out_last  = strobe && (out_idx == last_cell);
  assign left_edge = first_pending ? rtca_pkg::LEFT_EDGE_FIRST : rtca_pkg::LEFT_EDGE_LATER;

  a_capture_search: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |=> (state == rtca_pkg::ST_SEARCH))
    else $error("tick did not enter rule search");
  a_rule_in_search: assert property (@(posedge clk) disable iff (rst)
    rule_valid |-> (state == rtca_pkg::ST_SEARCH))
    else $error("rule broadcast outside search");
  a_ctl_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.capture, ctl.restart, ctl.commit, ctl.shift}))
    else $error("conflicting cell controls");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_last |=> !strobe && !busy)
    else $error("results continue after last cell");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (out_idx <= last_cell))
    else $error("result index beyond active cells");

endmodule

FILE: src/rule_table_cell_array_unit.sv
// rule_table_cell_array_unit: top level; configuration registers and the row of cells.
// Depends on rtca_pkg, rtca_seq and rtca_cell.

// A command is taken when start is high and busy is low. A rule write or a
// restart gives no result. A tick works on N active cells and searches
// rule_count rules (rule_count clamped to 64, N to 3..32): the rule table
// is one memory with one read port, so rules are broadcast to all cells one
// per cycle, lowest index first; the registered read is then drained, the
// per-cell report registers are loaded, and the reports then shift out of
// the row, one cell per cycle from the left. Each result stands on the
// result ports for exactly one cycle with strobe high; there is no
// back-pressure, so the receiver must take every result as it comes.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// should only be made while busy is low; a new initial_cell_state is taken
// by the cells only at the next restart, and is lost on reset. Rule entries
// are not cleared by reset and must be written before they are searched.

module rule_table_cell_array_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          cmd,
  input  logic [rtca_pkg::RULE_IDX_W-1:0]     rule_index,
  input  logic [rtca_pkg::SIG_W-1:0]          match_state,
  input  logic [rtca_pkg::SIG_W-1:0]          match_left,
  input  logic [rtca_pkg::SIG_W-1:0]          match_right,
  input  logic [rtca_pkg::SIG_W-1:0]          new_state,
  input  logic [rtca_pkg::SIG_W-1:0]          new_left_out,
  input  logic [rtca_pkg::SIG_W-1:0]          new_right_out,
  input  logic [1:0]                          led_action,
  input  logic                                cfg_we,
  input  logic [rtca_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rtca_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                strobe,
  output logic [rtca_pkg::CELL_IDX_W-1:0]     cell_index,
  output logic [rtca_pkg::SIG_W-1:0]          cell_state,
  output logic [rtca_pkg::SIG_W-1:0]          left_signal,
  output logic [rtca_pkg::SIG_W-1:0]          right_signal,
  output logic                                lamp,
  output logic                                changed,
  output logic                                last
);

  // configuration registers
  logic [rtca_pkg::NUM_CELLS_W-1:0] num_cells;
  logic [rtca_pkg::SIG_W-1:0]       init_state;
  logic [rtca_pkg::RULE_CNT_W-1:0]  rule_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cells  <= rtca_pkg::NUM_CELLS_W'(10);
      init_state <= '0;
      rule_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rtca_pkg::CFG_NUM_CELLS:  num_cells  <= cfg_data[rtca_pkg::NUM_CELLS_W-1:0];
        rtca_pkg::CFG_INIT_STATE: init_state <= cfg_data[rtca_pkg::SIG_W-1:0];
        rtca_pkg::CFG_RULE_COUNT: rule_count <= cfg_data[rtca_pkg::RULE_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped active cell count (as index of last cell) and searched rule count
  logic [rtca_pkg::CELL_IDX_W-1:0] last_cell;
  logic [rtca_pkg::RULE_CNT_W-1:0] n_rules;

  always_comb begin
    if (num_cells < rtca_pkg::NUM_CELLS_W'(rtca_pkg::MIN_CELLS))
      last_cell = rtca_pkg::CELL_IDX_W'(rtca_pkg::MIN_CELLS - 1);
    else if (num_cells > rtca_pkg::NUM_CELLS_W'(rtca_pkg::MAX_CELLS))
      last_cell = rtca_pkg::CELL_IDX_W'(rtca_pkg::MAX_CELLS - 1);
    else
      last_cell = rtca_pkg::CELL_IDX_W'(num_cells - 1'b1);
    if (rule_count > rtca_pkg::RULE_CNT_W'(rtca_pkg::MAX_RULES))
      n_rules = rtca_pkg::RULE_CNT_W'(rtca_pkg::MAX_RULES);
    else
      n_rules = rule_count;
  end

  rtca_pkg::rule_t     wr_rule;
  rtca_pkg::rule_t     rule;
  rtca_pkg::cell_ctl_t ctl;
  logic [rtca_pkg::SIG_W-1:0] left_edge;

  assign wr_rule = '{st: match_state, lin: match_left, rin: match_right,
                     nxt: new_state, lout: new_left_out, rout: new_right_out,
                     led: led_action};

  rtca_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .rule_index (rule_index),
    .wr_rule    (wr_rule),
    .last_cell  (last_cell),
    .n_rules    (n_rules),
    .ctl        (ctl),
    .rule       (rule),
    .left_edge  (left_edge),
    .busy       (busy),
    .strobe     (strobe),
    .out_idx    (cell_index),
    .out_last   (last)
  );

  // cell row: neighbor outputs feed inputs; reports shift toward cell 0
  logic [rtca_pkg::SIG_W-1:0] lout_w   [rtca_pkg::MAX_CELLS];
  logic [rtca_pkg::SIG_W-1:0] rout_w   [rtca_pkg::MAX_CELLS];
  rtca_pkg::report_t          report_w [rtca_pkg::MAX_CELLS];

  for (genvar i = 0; i < rtca_pkg::MAX_CELLS; i++) begin : g_cell
    logic [rtca_pkg::SIG_W-1:0] lin;
    logic [rtca_pkg::SIG_W-1:0] rin;
    logic                       is_last;
    logic                       active;
    rtca_pkg::report_t          rep_in;

    assign is_last = (last_cell == rtca_pkg::CELL_IDX_W'(i));
    assign active  = (rtca_pkg::CELL_IDX_W'(i) <= last_cell);

    if (i == 0) begin : g_left
      assign lin = left_edge;
    end else begin : g_inner_l
      assign lin = rout_w[i-1];
    end

    if (i == rtca_pkg::MAX_CELLS - 1) begin : g_right
      assign rin    = rtca_pkg::RIGHT_EDGE;
      assign rep_in = '0;
    end else begin : g_inner_r
      assign rin    = is_last ? rtca_pkg::RIGHT_EDGE : lout_w[i+1];
      assign rep_in = report_w[i+1];
    end

    rtca_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .rule       (rule),
      .init_state (init_state),
      .lin        (lin),
      .rin        (rin),
      .active     (active),
      .report_in  (rep_in),
      .report_out (report_w[i]),
      .lout       (lout_w[i]),
      .rout       (rout_w[i])
    );
  end

  // cell 0 holds the report being delivered
  assign cell_state   = report_w[0].st;
  assign left_signal  = report_w[0].lout;
  assign right_signal = report_w[0].rout;
  assign lamp         = report_w[0].lamp;
  assign changed      = report_w[0].changed;

endmodule
